// ===== hw/rtl/tcpu_pkg.sv =====
// Shared definitions for the toy CPU execute unit: widths, opcode codes
// and the operand decode. No dependencies.
`default_nettype none

package tcpu_pkg;

    localparam int DATA_WIDTH = 8;
    localparam int PC_WIDTH   = 8;
    localparam int INS_WIDTH  = 8;
    localparam int RF_DEPTH   = 16;
    localparam int DM_DEPTH   = 4;
    localparam int RF_AW      = $clog2(RF_DEPTH);
    localparam int DM_AW      = $clog2(DM_DEPTH);
    localparam int OUT_WIDTH  = PC_WIDTH + 1 + RF_AW + DATA_WIDTH + 1 + DM_AW;

    typedef enum logic [3:0] {
        OP_ADD   = 4'h0,
        OP_SUB   = 4'h1,
        OP_MOV   = 4'h2,
        OP_LOAD  = 4'h3,
        OP_STORE = 4'h4,
        OP_LOADI = 4'h5,
        OP_JMP   = 4'h6,
        OP_JZ    = 4'h7,
        OP_INC   = 4'h8,
        OP_DEC   = 4'h9,
        OP_AND   = 4'hA,
        OP_OR    = 4'hB,
        OP_NOP   = 4'hC
    } t_op;

    // Jumps, INC, DEC and NOP take a 4-bit dest; everything else bits 3:2.
    function automatic logic [RF_AW-1:0] tcpu_dest(input logic [INS_WIDTH-1:0] ins);
        logic [3:0] op;
        op = ins[7:4];
        if (op == OP_JMP || op == OP_JZ || op == OP_INC || op == OP_DEC || op == OP_NOP) begin
            return ins[3:0];
        end
        return {2'b00, ins[3:2]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcpu_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module tcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_wr_en,
    input  wire [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire [WIDTH-1:0]         i_wr_data,
    input  wire                     i_rd_en,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  wire [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]        o_rd_data_a,
    output logic [WIDTH-1:0]        o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data_a <= r_mem[i_rd_addr_a];
            o_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/toy_cpu_instruction_execute_unit.sv =====
// Toy CPU execute unit: one instruction byte in, one status transfer out.
// Depends on tcpu_pkg and tcpu_ram.
`default_nettype none

// One instruction per cycle, sustained while the output is not held off.
// An accepted instruction reads its dest and src registers from the register
// file RAM at the accept edge, is executed once the output register can take
// it (ALU, PC, Z and writeback), and its result is captured in the output
// register at the end of the execute cycle. The input stalls only while both
// the instruction register and the output register are full and the output
// is held off. A result of the instruction ahead is bypassed into the
// operands, so dependent instructions may follow back to back. The register
// file and data words read as zero after reset; there is no clearing pass.
module toy_cpu_instruction_execute_unit
    import tcpu_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire [INS_WIDTH-1:0]  s_axis_tdata,   // [7:0] instruction
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // [7:0] next_pc, [8] zero_flag, [12:9] dest_index, [20:13] dest_value,
    // [21] store_done, [23:22] store_index
    output logic [OUT_WIDTH-1:0] m_axis_tdata
);

    logic                  s_acc, adv, exe;
    logic                  r_ins_vld;
    logic [INS_WIDTH-1:0]  r_ins;
    logic [RF_AW-1:0]      rd_dest, rd_src;
    logic [RF_DEPTH-1:0]   r_rf_vld;
    logic                  r_vld_d, r_vld_s, r_byp_d, r_byp_s;
    logic [DATA_WIDTH-1:0] r_byp_val;
    logic [DATA_WIDTH-1:0] ram_a, ram_b;
    logic [DATA_WIDTH-1:0] r_dm [DM_DEPTH];
    logic [PC_WIDTH-1:0]   r_pc;
    logic                  r_z;
    logic                  r_out_vld;
    logic [OUT_WIDTH-1:0]  r_out;

    logic [RF_AW-1:0]      dest;
    logic [DM_AW-1:0]      src;
    t_op                   op;
    logic [DATA_WIDTH-1:0] a, b, res;
    logic                  wr_en, st_en, jump;
    logic [PC_WIDTH-1:0]   n_pc;
    logic                  n_z;

    assign adv           = !r_out_vld || m_axis_tready;
    assign exe           = r_ins_vld && adv;
    assign s_axis_tready = !r_ins_vld || adv;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign rd_dest = tcpu_dest(s_axis_tdata);
    assign rd_src  = RF_AW'(s_axis_tdata[1:0]);

    tcpu_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(RF_DEPTH)
    ) u_rf (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (dest),
        .i_wr_data   (res),
        .i_rd_en     (s_acc),
        .i_rd_addr_a (rd_dest),
        .i_rd_addr_b (rd_src),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    // Operand fetch side: bypass the write landing on the same edge.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_ins     <= s_axis_tdata;
            r_vld_d   <= r_rf_vld[rd_dest];
            r_vld_s   <= r_rf_vld[rd_src];
            r_byp_d   <= wr_en && (dest == rd_dest);
            r_byp_s   <= wr_en && (dest == rd_src);
            r_byp_val <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins_vld <= 1'b0;
        end else if (s_acc) begin
            r_ins_vld <= 1'b1;
        end else if (exe) begin
            r_ins_vld <= 1'b0;
        end
    end

    assign dest = tcpu_dest(r_ins);
    assign src  = r_ins[1:0];
    assign op   = t_op'(r_ins[7:4]);
    assign a    = r_byp_d ? r_byp_val : (r_vld_d ? ram_a : '0);
    assign b    = r_byp_s ? r_byp_val : (r_vld_s ? ram_b : '0);

    always_comb begin
        res   = a;
        wr_en = 1'b0;
        st_en = 1'b0;
        jump  = 1'b0;
        unique case (op)
            OP_ADD:   begin res = a + b;               wr_en = exe; end
            OP_SUB:   begin res = a - b;               wr_en = exe; end
            OP_MOV:   begin res = b;                   wr_en = exe; end
            OP_LOAD:  begin res = r_dm[src];           wr_en = exe; end
            OP_STORE: begin st_en = 1'b1; end
            OP_LOADI: begin res = DATA_WIDTH'(src);    wr_en = exe; end
            OP_JMP:   begin jump = 1'b1; end
            OP_JZ:    begin jump = r_z; end
            OP_INC:   begin res = a + DATA_WIDTH'(1);  wr_en = exe; end
            OP_DEC:   begin res = a - DATA_WIDTH'(1);  wr_en = exe; end
            OP_AND:   begin res = a & b;               wr_en = exe; end
            OP_OR:    begin res = a | b;               wr_en = exe; end
            default:  begin end
        endcase
    end

    always_comb begin
        if (jump) begin
            n_pc = PC_WIDTH'(dest);
            n_z  = r_z;
        end else begin
            n_pc = r_pc + PC_WIDTH'(1);
            n_z  = (res == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= '0;
            r_z      <= 1'b0;
            r_rf_vld <= '0;
            for (int i = 0; i < DM_DEPTH; i++) begin
                r_dm[i] <= '0;
            end
        end else if (exe) begin
            r_pc <= n_pc;
            r_z  <= n_z;
            if (wr_en) begin
                r_rf_vld[dest] <= 1'b1;
            end
            if (st_en) begin
                r_dm[src] <= a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exe) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exe) begin
            r_out <= {(st_en ? src : DM_AW'(0)), st_en, res, dest, n_z, n_pc};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ===== hw/rtl/tcpu_checker.sv =====
// Port-level checks for the toy CPU execute unit, bound to the top level.
// Depends on tcpu_pkg.
`default_nettype none

module tcpu_checker
    import tcpu_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [OUT_WIDTH-1:0]  m_axis_tdata
);

    // No result right after reset.
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled transfer holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Store word index reads zero unless a store happened.
    a_st_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[21] |-> m_axis_tdata[23:22] == 2'b00)
        else $error("store index without store");

    // A store names one of the four low registers.
    a_st_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[21] |-> m_axis_tdata[12:11] == 2'b00)
        else $error("store with wide dest");

endmodule

bind toy_cpu_instruction_execute_unit tcpu_checker u_tcpu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
